/* rtl/positional_ordered_list_macros.svh */
// Assertion macros used by the checker of the ordered list.
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define POL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define POL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list check failed");

`endif

/* rtl/pol_pkg.sv */
`default_nettype none

package pol_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOPOS = 2'd1,
        ST_UNDER = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_DELETE = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [4:0]         position;
        logic signed [31:0] value;
    } pol_item_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] removed_value;
        logic [4:0]         entry_count;
    } pol_result_t;

endpackage

`default_nettype wire

/* rtl/pol_cells.sv */
`default_nettype none

module pol_cells
    import pol_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire pol_item_t   op,
    output pol_result_t      res
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PW = ((CW > 5) ? CW : 5) + 1;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic signed [31:0] entry_reg [DEPTH];
    logic signed [31:0] entry_next [DEPTH];

    logic [PW-1:0]      pos_w;
    logic [PW-1:0]      cnt_w;
    logic               do_ins;
    logic               do_del;
    status_t            status;
    logic signed [31:0] picked;

    always_comb
    begin
        pos_w  = PW'(op.position);
        cnt_w  = PW'(count_reg);
        do_ins = 1'b0;
        do_del = 1'b0;
        status = ST_OK;
        case (op.mode)
            MODE_INSERT:
            begin
                if (cnt_w == PW'(DEPTH))
                    status = ST_FULL;
                else if (pos_w == '0 || pos_w > cnt_w + PW'(1))
                    status = ST_NOPOS;
                else
                    do_ins = 1'b1;
            end
            MODE_DELETE:
            begin
                if (cnt_w == '0)
                    status = ST_UNDER;
                else if (pos_w == '0 || pos_w > cnt_w)
                    status = ST_NOPOS;
                else
                    do_del = 1'b1;
            end
            default:
                status = ST_OK;
        endcase
    end

    // Every cell knows its own 1-based place and decides in parallel whether
    // it keeps its word, takes the new one, or takes a neighbor's.
    always_comb
    begin
        picked = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
            if (PW'(i) + PW'(1) == pos_w)
                picked = picked | entry_reg[i];
            if (do_ins)
            begin
                if (PW'(i) + PW'(1) == pos_w)
                    entry_next[i] = op.value;
                else if (PW'(i) + PW'(1) > pos_w)
                    entry_next[i] = entry_reg[(i == 0) ? 0 : i - 1];
            end
            else if (do_del)
            begin
                if (PW'(i) + PW'(1) >= pos_w)
                    entry_next[i] = entry_reg[(i + 1 < DEPTH) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        if (do_ins)
            count_next = count_reg + CW'(1);
        else if (do_del)
            count_next = count_reg - CW'(1);
        else
            count_next = count_reg;
    end

    assign res.status        = status;
    assign res.removed_value = do_del ? picked : 32'sd0;
    assign res.entry_count   = 5'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (fire)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && (do_ins || do_del))
            entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

/* rtl/positional_ordered_list.sv */
// Ordered list of up to DEPTH signed 32-bit words with positional insert
// and delete.
// The item channel (item_valid, item_stall, item) carries one operation: an
// insert of a value at a 1-based position, or a delete at a position.
// The result channel (result_valid, result_stall, result) returns one word
// per operation: status, the removed value (zero unless a delete succeeds)
// and the entry count after the operation.
// An item is captured in the input register; when it advances, the cell
// row is updated and the result register loaded in the same cycle.
// Throughput is one item per cycle while the receiver does not stall; every
// cell shifts in the same cycle, so the cell row's update sets the rate.
// Reset empties the list and clears both registers' valid flags; the stored
// words keep whatever they held and are never read until written again.
// When the receiver stalls, the result holds, then the input register
// fills and item_stall rises, so each side is buffered by its own register.
`default_nettype none

module positional_ordered_list
    import pol_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire pol_item_t   item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output pol_result_t      result
);

    logic        stage_valid_reg;
    logic        stage_valid_next;
    pol_item_t   stage_reg;
    logic        result_valid_reg;
    logic        result_valid_next;
    pol_result_t result_reg;
    pol_result_t cell_res;
    logic        advance;
    logic        item_take;

    assign advance    = stage_valid_reg && !(result_valid_reg && result_stall);
    assign item_stall = stage_valid_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    assign stage_valid_next  = item_take || (stage_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && result_stall);

    pol_cells #(
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .op    (stage_reg),
        .res   (cell_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            stage_reg <= item;
        if (advance)
            result_reg <= cell_res;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* rtl/pol_checker.sv */
`default_nettype none

`include "positional_ordered_list_macros.svh"

module pol_checker
    import pol_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_stall,
    input  wire logic        result_valid,
    input  wire logic        result_stall,
    input  wire pol_result_t result
);

    logic [31:0] depth_w;
    logic        res_held;
    logic        res_refused;
    logic        res_under;

    assign depth_w     = 32'(DEPTH);
    assign res_held    = result_valid && result_stall;
    assign res_refused = result_valid && result.status != ST_OK;
    assign res_under   = result_valid && result.status == ST_UNDER;

    // A stalled result word stays on the port unchanged.
    `POL_ASSERT_NXT(a_result_hold, clk, rst_n, res_held, result_valid && $stable(result))

    // The input side only stalls while a result word is waiting on a stalled receiver.
    `POL_ASSERT_IMP(a_stall_cause, clk, rst_n, item_stall, res_held)

    // The list never reports more entries than it can hold.
    `POL_ASSERT_IMP(a_count_bound, clk, rst_n, result_valid, 32'(result.entry_count) <= depth_w)

    // Only a successful delete carries a removed value.
    `POL_ASSERT_IMP(a_removed_zero, clk, rst_n, res_refused, result.removed_value == 32'sd0)

    // Underflow is only reported on an empty list.
    `POL_ASSERT_IMP(a_under_empty, clk, rst_n, res_under, result.entry_count == 5'd0)

endmodule

bind positional_ordered_list pol_checker #(.DEPTH(DEPTH)) u_pol_checker (.*);

`default_nettype wire
